### hw/rtl/fsc_pkg.sv
// Shared constants and types for the frustum sphere culling unit.
package fsc_pkg;

  localparam int unsigned NUM_REGS      = 8;
  localparam int unsigned NUM_PLANES    = 6;
  localparam int unsigned REG_W         = 64;
  localparam int unsigned ADDR_W        = $clog2(NUM_REGS * 8);
  localparam int unsigned DATA_W_DEF    = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned RADIUS_W      = 31;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_regs_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_SQ,
    ST_ROOT,
    ST_DLOAD,
    ST_DIV,
    ST_STORE
  } setup_st_e;

endpackage

### hw/rtl/fsc_plane_setup.sv
// Plane extraction and normalisation from the matrix registers (shared sqrt and divider).
module fsc_plane_setup #(
  parameter int unsigned DATA_WIDTH = fsc_pkg::DATA_W_DEF,
  parameter int unsigned FRAC_BITS  = fsc_pkg::FRAC_BITS_DEF,
  localparam int unsigned UW = FRAC_BITS + 2,
  localparam int unsigned EW = DATA_WIDTH + FRAC_BITS + 1
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  fsc_pkg::cfg_regs_t                         regs_i,
  output logic                                       busy_o,
  output logic [fsc_pkg::NUM_PLANES-1:0]             plane_ok_o,
  output logic [fsc_pkg::NUM_PLANES-1:0][2:0][UW-1:0] unit_o,
  output logic [fsc_pkg::NUM_PLANES-1:0][EW-1:0]     offset_o
);
  import fsc_pkg::*;

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned NW  = W + F;
  localparam int unsigned CW  = $clog2(NW + 1);
  localparam logic [2:0] LAST_PLANE = 3'(NUM_PLANES - 1);

  setup_st_e state_q, state_d;

  logic [2:0]            plane_q;
  logic [1:0]            idx_q;
  logic [CW-1:0]         cnt_q;
  logic [3:0][W-1:0]     comp_q;
  logic [3:0][W-1:0]     comp_d;
  logic [2*W-1:0]        sq_q;
  logic [2*W-1:0]        len2_q;
  logic [W-1:0]          root_q;
  logic [W+1:0]          srem_q;
  logic [NW-1:0]         num_q;
  logic [W-1:0]          drem_q;
  logic [NW-1:0]         quot_q;
  logic                  neg_q;

  logic [NUM_PLANES-1:0]             ok_q;
  logic [NUM_PLANES-1:0][2:0][UW-1:0] unit_q;
  logic [NUM_PLANES-1:0][EW-1:0]     offs_q;

  logic [W-1:0]    cur_comp;
  logic [W-1:0]    cur_mag;
  logic [W+2:0]    sq_rem;
  logic [W+2:0]    sq_trial;
  logic            sq_take;
  logic [W:0]      dv_rem;
  logic            dv_take;
  logic [EW-1:0]   q_signed;
  logic [1:0]      row;

  // Saturated plane components: row 3 plus or minus the selected row
  always_comb begin
    logic signed [W:0] a;
    logic signed [W:0] b;
    logic signed [W:0] s;
    row = 2'(plane_q >> 1);
    for (int j = 0; j < 4; j++) begin
      a = (W+1)'($signed(regs_i[{2'd3, 1'(j >> 1)}][(j % 2) * 32 +: W]));
      b = (W+1)'($signed(regs_i[{row, 1'(j >> 1)}][(j % 2) * 32 +: W]));
      s = plane_q[0] ? a - b : a + b;
      if (s[W] != s[W-1]) begin
        comp_d[j] = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        comp_d[j] = s[W-1:0];
      end
    end
  end

  always_comb begin
    cur_comp = comp_q[idx_q];
    cur_mag  = cur_comp[W-1] ? W'(-cur_comp) : cur_comp;
    sq_rem   = {srem_q[W:0], len2_q[2*W-1 -: 2]};
    sq_trial = {1'b0, root_q, 2'b01};
    sq_take  = sq_rem >= sq_trial;
    dv_rem   = {drem_q, num_q[NW-1]};
    dv_take  = dv_rem >= {1'b0, root_q};
    q_signed = neg_q ? EW'(-{1'b0, quot_q}) : {1'b0, quot_q};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  state_d = ST_IDLE;
      ST_COMP:  state_d = ST_SQ;
      ST_SQ:    if (idx_q == 2'd3) state_d = ST_ROOT;
      ST_ROOT:  if (cnt_q == CW'(W - 1)) state_d = ST_DLOAD;
      ST_DLOAD: begin
        if (root_q == '0) begin
          state_d = (plane_q == LAST_PLANE) ? ST_IDLE : ST_COMP;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV:   if (cnt_q == CW'(NW - 1)) state_d = ST_STORE;
      ST_STORE: begin
        if (idx_q != 2'd3) begin
          state_d = ST_DLOAD;
        end else begin
          state_d = (plane_q == LAST_PLANE) ? ST_IDLE : ST_COMP;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
    if (start_i) state_d = ST_COMP;
  end

  always_comb begin
    busy_o = (state_q != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      plane_q <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      ok_q    <= '0;
    end else begin
      state_q <= state_d;
      if (start_i) begin
        plane_q <= '0;
      end else begin
        case (state_q)
          ST_COMP: begin
            idx_q <= '0;
            cnt_q <= '0;
          end
          ST_SQ:    idx_q <= (idx_q == 2'd3) ? 2'd0 : idx_q + 2'd1;
          ST_ROOT:  cnt_q <= (cnt_q == CW'(W - 1)) ? '0 : cnt_q + 1'b1;
          ST_DLOAD: begin
            cnt_q <= '0;
            if (root_q == '0) begin
              ok_q[plane_q] <= 1'b0;
              plane_q       <= plane_q + 3'd1;
            end
          end
          ST_DIV:   cnt_q <= cnt_q + 1'b1;
          ST_STORE: begin
            ok_q[plane_q] <= 1'b1;
            if (idx_q == 2'd3) begin
              idx_q   <= '0;
              plane_q <= plane_q + 3'd1;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_COMP: begin
        comp_q <= comp_d;
        srem_q <= '0;
        root_q <= '0;
      end
      ST_SQ: begin
        sq_q   <= cur_mag * cur_mag;
        len2_q <= (idx_q == 2'd0) ? '0 : len2_q + sq_q;
      end
      ST_ROOT: begin
        len2_q <= len2_q << 2;
        if (sq_take) begin
          srem_q <= (W+2)'(sq_rem - sq_trial);
          root_q <= {root_q[W-2:0], 1'b1};
        end else begin
          srem_q <= sq_rem[W+1:0];
          root_q <= {root_q[W-2:0], 1'b0};
        end
      end
      ST_DLOAD: begin
        num_q  <= NW'(cur_mag) << F;
        neg_q  <= cur_comp[W-1];
        drem_q <= '0;
        quot_q <= '0;
      end
      ST_DIV: begin
        num_q  <= num_q << 1;
        quot_q <= {quot_q[NW-2:0], dv_take};
        drem_q <= dv_take ? W'(dv_rem - {1'b0, root_q}) : dv_rem[W-1:0];
      end
      ST_STORE: begin
        if (idx_q == 2'd3) begin
          offs_q[plane_q] <= q_signed;
        end else begin
          unit_q[plane_q][idx_q] <= q_signed[UW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign plane_ok_o = ok_q;
  assign unit_o     = unit_q;
  assign offset_o   = offs_q;

endmodule

### hw/rtl/frustum_sphere_cull_unit.sv
// Frustum sphere culling unit: matrix registers, plane setup and the test pipeline.
//
// Usage: write the view-projection matrix over the APB port, two Q16.16
// elements per 64-bit register (row R at byte addresses 16*R and 16*R+8).
// Each write restarts the plane setup, which extracts six planes and
// normalises them with a bit-serial square root and a restoring divider
// shared by all planes (a degenerate plane skips its divisions), and
// in_stall_o is high throughout. Then spheres stream in on the input
// channel, one transaction per cycle unless in_stall_o is high; each
// result passes through the input, multiply, sum and compare registers
// before it appears on the output channel.
// The 18 parallel multipliers take one sphere per cycle unless the output stalls.
// At reset the registers clear, every plane is marked degenerate and all
// spheres are reported visible. When the receiver stalls, results wait in
// the pipeline stages; bubbles close up, and the input is stalled only once
// every stage holds a transaction.
module frustum_sphere_cull_unit #(
  parameter int unsigned DATA_WIDTH = fsc_pkg::DATA_W_DEF,
  parameter int unsigned FRAC_BITS  = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fsc_pkg::ADDR_W-1:0]     paddr,
  input  logic [fsc_pkg::REG_W-1:0]      pwdata,
  output logic [fsc_pkg::REG_W-1:0]      prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [fsc_pkg::COORD_W-1:0]    center_x_i,
  input  logic [fsc_pkg::COORD_W-1:0]    center_y_i,
  input  logic [fsc_pkg::COORD_W-1:0]    center_z_i,
  input  logic [fsc_pkg::RADIUS_W-1:0]   sphere_radius_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           visible_o
);
  import fsc_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned UW = F + 2;
  localparam int unsigned EW = W + F + 1;
  localparam int unsigned PW = UW + W;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned TW = W + F + 3;

  cfg_regs_t cfg_q;
  logic      cfg_we;
  logic      busy;

  logic [NUM_PLANES-1:0]              plane_ok;
  logic [NUM_PLANES-1:0][2:0][UW-1:0] unit;
  logic [NUM_PLANES-1:0][EW-1:0]      offs;

  assign cfg_we = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = cfg_q[paddr[ADDR_W-1:3]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we) begin
      cfg_q[paddr[ADDR_W-1:3]] <= pwdata;
    end
  end

  fsc_plane_setup #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_setup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_we),
    .regs_i     (cfg_q),
    .busy_o     (busy),
    .plane_ok_o (plane_ok),
    .unit_o     (unit),
    .offset_o   (offs)
  );

  // Test pipeline with per-stage flow control
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [W-1:0] c1_q [3];
  logic [W-2:0]        r1_q, r2_q, r3_q;
  logic signed [PW-1:0] prod_q [NUM_PLANES][3];
  logic signed [SW-1:0] sum_q  [NUM_PLANES];
  logic                 vis_q;
  logic                 vis_d;

  assign rdy4       = !v4_q || !out_stall_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = busy || !rdy1;

  always_comb begin
    logic signed [TW-1:0] t;
    vis_d = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      t = TW'(sum_q[p] >>> F) + TW'($signed(offs[p])) + $signed(TW'(r3_q));
      if (plane_ok[p] && t[TW-1]) vis_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i && !busy;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i && !busy) begin
      c1_q[0] <= $signed(center_x_i[W-1:0]);
      c1_q[1] <= $signed(center_y_i[W-1:0]);
      c1_q[2] <= $signed(center_z_i[W-1:0]);
      r1_q    <= sphere_radius_i[W-2:0];
    end
    if (rdy2 && v1_q) begin
      r2_q <= r1_q;
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[p][j] <= PW'($signed(unit[p][j])) * PW'(c1_q[j]);
        end
      end
    end
    if (rdy3 && v2_q) begin
      r3_q <= r2_q;
      for (int p = 0; p < NUM_PLANES; p++) begin
        sum_q[p] <= SW'(prod_q[p][0]) + SW'(prod_q[p][1]) + SW'(prod_q[p][2]);
      end
    end
    if (rdy4 && v3_q) begin
      vis_q <= vis_d;
    end
  end

  assign out_valid_o = v4_q;
  assign visible_o   = vis_q;

  // A register write must hold off new spheres from the next cycle on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> in_stall_o)
    else $error("input not stalled after a matrix write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> in_stall_o)
    else $error("sphere accepted while planes are being set up");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted transaction lost at the first stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && v4_q && out_stall_i) |=> v3_q)
    else $error("pipeline stage dropped a transaction under stall");

endmodule
